/* hdl/gct_pkg.sv */
// Shared types, widths and constants for the great-circle travel time block.
// Holds the CORDIC arctangent table and the structs passed between the cells.
// No dependencies.
package gct_pkg;

  // Widths of the datapath.
  localparam int CW     = 34;  // CORDIC x, y and z, signed Q30
  localparam int SPD_W  = 26;  // ground speed, Q10.16
  localparam int AQ_W   = 31;  // haversine term a, Q30 in [0, 1]
  localparam int SV_W   = 61;  // square root radicand
  localparam int SR_W   = 62;  // square root work register
  localparam int ZQ_W   = 31;  // clamped central half angle, Q30
  localparam int RAD_W  = 24;  // sphere radius in metres
  localparam int NUM_W  = 56;  // dividend, radius times angle
  localparam int DEN_W  = 32;  // divisor, speed shifted by six
  localparam int TIME_W = 40;  // travel time, Q32.8

  localparam int TAB_LEN    = 40;
  localparam int SQRT_STEPS = 31;  // radicand never exceeds 2^60

  localparam logic [CW-1:0]     K_GAIN   = CW'(652032874);
  localparam logic [34:0]       K_PI     = 35'd3373259426;
  localparam logic [34:0]       K_HALFPI = 35'd1686629713;
  localparam logic [AQ_W-1:0]   K_ONE    = AQ_W'(1073741824);
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Arctangent of 2^-i, truncated to Q30.
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535,
    32'd32767, 32'd16383, 32'd8191, 32'd4095, 32'd2047,
    32'd1023, 32'd511, 32'd255, 32'd127, 32'd63,
    32'd31, 32'd15, 32'd7, 32'd3, 32'd1,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  // Four rotation lanes: half latitude and longitude differences, two latitudes.
  typedef struct packed {
    logic [3:0][CW-1:0] x;
    logic [3:0][CW-1:0] y;
    logic [3:0][CW-1:0] z;
    logic [3:0]         flip;
    logic [SPD_W-1:0]   speed;
  } gct_rot_t;

  // Two square root lanes: sqrt(a) and sqrt(1 - a).
  typedef struct packed {
    logic [1:0][SV_W-1:0] v;
    logic [1:0][SR_W-1:0] r;
    logic [SPD_W-1:0]     speed;
  } gct_sqrt_t;

  // Vectoring CORDIC for atan2.
  typedef struct packed {
    logic [CW-1:0]    x;
    logic [CW-1:0]    y;
    logic [CW-1:0]    z;
    logic [SPD_W-1:0] speed;
  } gct_vec_t;

  // Restoring divider: partial remainder, dividend turning into quotient.
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } gct_div_t;

endpackage

/* hdl/great_circle_travel_time.sv */
// Great-circle travel time: haversine distance over a sphere divided by speed.
// Depends on gct_pkg and the cells gct_rot_cell, gct_sqrt_cell, gct_vec_cell
// and gct_div_cell.
//
// Usage: a point pair and a ground speed are transferred at a rising edge with
// start high and busy low. busy is always low, so one item may be transferred
// in every cycle. Each item gives exactly one result, shown on the result ports
// with done_o high for one cycle, in the order of the inputs.
// The pipeline holds the angle reduction register, a sine/cosine cell row,
// three multiply stages, 31 square root cells, an arctangent cell row, one
// multiply stage, 56 divider cells and the output register. Throughput is
// one item per cycle.
// The radius register is written with cfg_we_i and cfg_wdata_i; it is read in
// flight, so write it only while no item is in the pipeline.
// Reset clears the pipeline valid bits and loads the radius 6371000 m; items
// in flight are dropped. The receiver cannot stall: each result is transferred
// in its one cycle of done_o.
// Zero speed gives the maximum time with speed_zero_o set; a time beyond 40
// bits is clamped with time_saturated_o set.
module great_circle_travel_time #(
  parameter int CORDIC_STAGES = 28
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gct_pkg::RAD_W-1:0]           cfg_wdata_i,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [29:0]                  start_lat_i,
  input  logic signed [30:0]                  start_lon_i,
  input  logic signed [29:0]                  end_lat_i,
  input  logic signed [30:0]                  end_lon_i,
  input  logic [gct_pkg::SPD_W-1:0]           ground_speed_i,
  output logic                                done_o,
  output logic [gct_pkg::TIME_W-1:0]          travel_seconds_o,
  output logic                                time_saturated_o,
  output logic                                speed_zero_o
);
  import gct_pkg::*;

  localparam int N   = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
  localparam int LAT = 2 * N + 93;

  // Control state.
  logic [RAD_W-1:0] radius_q;
  logic [LAT-1:0]   vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RAD_W'(6371000);
      vld_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      vld_q <= {vld_q[LAT-2:0], start};
    end
  end

  assign busy   = 1'b0;
  assign done_o = vld_q[LAT-1];

  // Half differences and latitudes in Q30, brought into +-pi/2.
  gct_rot_t rot_d;
  always_comb begin
    logic signed [34:0] ang [4];
    logic [3:0]         flp;
    ang[0] = (35'(end_lat_i) - 35'(start_lat_i)) <<< 1;
    ang[1] = (35'(end_lon_i) - 35'(start_lon_i)) <<< 1;
    ang[2] = 35'(start_lat_i) <<< 2;
    ang[3] = 35'(end_lat_i) <<< 2;
    flp    = '0;
    for (int l = 0; l < 4; l++) begin
      for (int m = 0; m < 4; m++) begin
        if (ang[l] > $signed(K_HALFPI)) begin
          ang[l] = ang[l] - $signed(K_PI);
          flp[l] = ~flp[l];
        end else if (ang[l] < -$signed(K_HALFPI)) begin
          ang[l] = ang[l] + $signed(K_PI);
          flp[l] = ~flp[l];
        end
      end
    end
    for (int l = 0; l < 4; l++) begin
      rot_d.x[l] = K_GAIN;
      rot_d.y[l] = '0;
      rot_d.z[l] = ang[l][CW-1:0];
    end
    rot_d.flip  = flp;
    rot_d.speed = ground_speed_i;
  end

  // Sine and cosine cell row.
  gct_rot_t rot_ch [N+1];
  always_ff @(posedge clk_i) begin
    rot_ch[0] <= rot_d;
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    gct_rot_cell #(.IDX(i)) u_cell (
      .clk_i (clk_i),
      .in_i  (rot_ch[i]),
      .out_o (rot_ch[i+1])
    );
  end

  // Squares and the cosine product.
  logic signed [CW-1:0] p_lat_q, p_lon_q, p_c_q, p_lat2_q, q_q;
  logic [SPD_W-1:0]     spd1_q, spd2_q, spd3_q;
  logic [AQ_W-1:0]      a_q;

  logic signed [CW-1:0]   s_lat, s_lon, c_one, c_two;
  logic signed [2*CW-1:0] m_lat, m_lon, m_c, m_q;
  logic signed [CW:0]     a_sum;

  always_comb begin
    s_lat = rot_ch[N].flip[0] ? -$signed(rot_ch[N].y[0]) : $signed(rot_ch[N].y[0]);
    s_lon = rot_ch[N].flip[1] ? -$signed(rot_ch[N].y[1]) : $signed(rot_ch[N].y[1]);
    c_one = rot_ch[N].flip[2] ? -$signed(rot_ch[N].x[2]) : $signed(rot_ch[N].x[2]);
    c_two = rot_ch[N].flip[3] ? -$signed(rot_ch[N].x[3]) : $signed(rot_ch[N].x[3]);
    m_lat = s_lat * s_lat;
    m_lon = s_lon * s_lon;
    m_c   = c_one * c_two;
    m_q   = p_c_q * p_lon_q;
    a_sum = (CW+1)'(p_lat2_q) + (CW+1)'(q_q);
  end

  always_ff @(posedge clk_i) begin
    p_lat_q  <= m_lat[CW+29:30];
    p_lon_q  <= m_lon[CW+29:30];
    p_c_q    <= m_c[CW+29:30];
    spd1_q   <= rot_ch[N].speed;
    p_lat2_q <= p_lat_q;
    q_q      <= m_q[CW+29:30];
    spd2_q   <= spd1_q;
    spd3_q   <= spd2_q;
    if (a_sum < 0) begin
      a_q <= '0;
    end else if (a_sum > $signed((CW+1)'(K_ONE))) begin
      a_q <= K_ONE;
    end else begin
      a_q <= a_sum[AQ_W-1:0];
    end
  end

  // Square root cell row for sqrt(a) and sqrt(1 - a).
  gct_sqrt_t sq_ch [SQRT_STEPS+1];
  logic [AQ_W-1:0] a_inv;
  assign a_inv = K_ONE - a_q;

  always_comb begin
    sq_ch[0].v[0]  = {a_q, 30'b0};
    sq_ch[0].v[1]  = {a_inv, 30'b0};
    sq_ch[0].r     = '0;
    sq_ch[0].speed = spd3_q;
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    gct_sqrt_cell #(.K(SQRT_STEPS - 1 - j)) u_cell (
      .clk_i (clk_i),
      .in_i  (sq_ch[j]),
      .out_o (sq_ch[j+1])
    );
  end

  // Arctangent cell row, y = sqrt(a), x = sqrt(1 - a).
  gct_vec_t vec_ch [N+1];
  always_comb begin
    vec_ch[0].x     = CW'(sq_ch[SQRT_STEPS].r[1][AQ_W-1:0]);
    vec_ch[0].y     = CW'(sq_ch[SQRT_STEPS].r[0][AQ_W-1:0]);
    vec_ch[0].z     = '0;
    vec_ch[0].speed = sq_ch[SQRT_STEPS].speed;
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    gct_vec_cell #(.IDX(i)) u_cell (
      .clk_i (clk_i),
      .in_i  (vec_ch[i]),
      .out_o (vec_ch[i+1])
    );
  end

  // Distance, radius times the central angle, and the scaled speed.
  logic [ZQ_W-1:0] z_clamp;
  gct_div_t        div_src_q;
  assign z_clamp = $signed(vec_ch[N].z) < 0 ? '0 : vec_ch[N].z[ZQ_W-1:0];

  always_ff @(posedge clk_i) begin
    div_src_q.rem <= '0;
    div_src_q.num <= NUM_W'(radius_q) * NUM_W'({z_clamp, 1'b0});
    div_src_q.den <= {vec_ch[N].speed, 6'b0};
  end

  // Divider cell row.
  gct_div_t div_ch [NUM_W+1];
  assign div_ch[0] = div_src_q;

  for (genvar j = 0; j < NUM_W; j++) begin : g_div
    gct_div_cell u_cell (
      .clk_i (clk_i),
      .in_i  (div_ch[j]),
      .out_o (div_ch[j+1])
    );
  end

  // Output register with the special cases.
  always_ff @(posedge clk_i) begin
    if (div_ch[NUM_W].den == '0) begin
      travel_seconds_o <= TIME_MAX;
      time_saturated_o <= 1'b0;
      speed_zero_o     <= 1'b1;
    end else if (|div_ch[NUM_W].num[NUM_W-1:TIME_W]) begin
      travel_seconds_o <= TIME_MAX;
      time_saturated_o <= 1'b1;
      speed_zero_o     <= 1'b0;
    end else begin
      travel_seconds_o <= div_ch[NUM_W].num[TIME_W-1:0];
      time_saturated_o <= 1'b0;
      speed_zero_o     <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_done_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result without a matching transfer");
  a_zero_gives_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && speed_zero_o) |-> (travel_seconds_o == TIME_MAX && !time_saturated_o))
    else $error("zero speed without maximum time");
  a_sat_gives_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && time_saturated_o) |-> (travel_seconds_o == TIME_MAX && !speed_zero_o))
    else $error("saturation without maximum time");
`endif

endmodule

/* hdl/gct_rot_cell.sv */
// One rotation CORDIC cell, four lanes in parallel, for sine and cosine.
// Depends on gct_pkg.
module gct_rot_cell #(
  parameter int IDX = 0
) (
  input  logic             clk_i,
  input  gct_pkg::gct_rot_t in_i,
  output gct_pkg::gct_rot_t out_o
);
  import gct_pkg::*;

  localparam logic signed [CW-1:0] ATAN_C = CW'(ATAN_TAB[IDX]);

  gct_rot_t cell_d, cell_q;

  // Rotate each lane towards zero residual angle.
  always_comb begin
    logic signed [CW-1:0] xs, ys, zs, dx, dy;
    cell_d = in_i;
    for (int l = 0; l < 4; l++) begin
      xs = in_i.x[l];
      ys = in_i.y[l];
      zs = in_i.z[l];
      dx = ys >>> IDX;
      dy = xs >>> IDX;
      if (zs >= 0) begin
        cell_d.x[l] = xs - dx;
        cell_d.y[l] = ys + dy;
        cell_d.z[l] = zs - ATAN_C;
      end else begin
        cell_d.x[l] = xs + dx;
        cell_d.y[l] = ys - dy;
        cell_d.z[l] = zs + ATAN_C;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign out_o = cell_q;

endmodule

/* hdl/gct_sqrt_cell.sv */
// One digit cell of a floor integer square root, two lanes in parallel.
// Depends on gct_pkg.
module gct_sqrt_cell #(
  parameter int K = 0
) (
  input  logic              clk_i,
  input  gct_pkg::gct_sqrt_t in_i,
  output gct_pkg::gct_sqrt_t out_o
);
  import gct_pkg::*;

  localparam logic [SR_W-1:0] BIT_C = SR_W'(1) << (2 * K);

  gct_sqrt_t cell_d, cell_q;

  // Try to subtract the trial value and shift in one root bit.
  always_comb begin
    logic [SR_W-1:0] trial;
    cell_d = in_i;
    for (int l = 0; l < 2; l++) begin
      trial = in_i.r[l] + BIT_C;
      if ({1'b0, in_i.v[l]} >= trial) begin
        cell_d.v[l] = in_i.v[l] - trial[SV_W-1:0];
        cell_d.r[l] = (in_i.r[l] >> 1) + BIT_C;
      end else begin
        cell_d.r[l] = in_i.r[l] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign out_o = cell_q;

endmodule

/* hdl/gct_vec_cell.sv */
// One vectoring CORDIC cell, accumulating the arctangent of y over x.
// Depends on gct_pkg.
module gct_vec_cell #(
  parameter int IDX = 0
) (
  input  logic             clk_i,
  input  gct_pkg::gct_vec_t in_i,
  output gct_pkg::gct_vec_t out_o
);
  import gct_pkg::*;

  localparam logic signed [CW-1:0] ATAN_C = CW'(ATAN_TAB[IDX]);

  gct_vec_t cell_d, cell_q;

  // Rotate the vector towards the x axis.
  always_comb begin
    logic signed [CW-1:0] xs, ys, zs, dx, dy;
    cell_d = in_i;
    xs = in_i.x;
    ys = in_i.y;
    zs = in_i.z;
    dx = ys >>> IDX;
    dy = xs >>> IDX;
    if (ys >= 0) begin
      cell_d.x = xs + dx;
      cell_d.y = ys - dy;
      cell_d.z = zs + ATAN_C;
    end else begin
      cell_d.x = xs - dx;
      cell_d.y = ys + dy;
      cell_d.z = zs - ATAN_C;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign out_o = cell_q;

endmodule

/* hdl/gct_div_cell.sv */
// One restoring division cell producing one quotient bit.
// Depends on gct_pkg.
module gct_div_cell (
  input  logic             clk_i,
  input  gct_pkg::gct_div_t in_i,
  output gct_pkg::gct_div_t out_o
);
  import gct_pkg::*;

  gct_div_t cell_d, cell_q;

  // Bring down the next dividend bit and subtract the divisor if it fits.
  always_comb begin
    logic [DEN_W:0] part;
    logic           qbit;
    part = {in_i.rem, in_i.num[NUM_W-1]};
    qbit = (part >= {1'b0, in_i.den});
    if (qbit) begin
      part = part - {1'b0, in_i.den};
    end
    cell_d.rem = part[DEN_W-1:0];
    cell_d.num = {in_i.num[NUM_W-2:0], qbit};
    cell_d.den = in_i.den;
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign out_o = cell_q;

endmodule

/* dv/tb.sv */
// Self-checking testbench for the great-circle travel time block.
// Depends on gct_pkg and great_circle_travel_time; a built-in predictor checks each result.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gct_pkg::*;

  localparam int     ROT_STAGES = 28;
  localparam int     LATENCY    = 2 * ROT_STAGES + 93;
  localparam int     IDLE_LIMIT = 20000;
  localparam longint ONE_Q30    = 64'sd1073741824;
  localparam longint PI_Q30     = 64'sd3373259426;
  localparam longint HPI_Q30    = 64'sd1686629713;
  localparam longint LAT_MAX    = 421657428;
  localparam longint LON_MAX    = 843314857;
  localparam logic [RAD_W-1:0] RADIUS_EARTH = RAD_W'(6371000);

  typedef struct {
    logic [TIME_W-1:0] secs;
    logic              sat;
    logic              zero;
  } trip_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [RAD_W-1:0]        cfg_wdata_i = '0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [29:0]      start_lat_i = '0;
  logic signed [30:0]      start_lon_i = '0;
  logic signed [29:0]      end_lat_i = '0;
  logic signed [30:0]      end_lon_i = '0;
  logic [SPD_W-1:0]        ground_speed_i = '0;
  logic                    done_o;
  logic [TIME_W-1:0]       travel_seconds_o;
  logic                    time_saturated_o;
  logic                    speed_zero_o;

  logic [RAD_W-1:0]        radius_m = RADIUS_EARTH;
  trip_t                   pending_trips[$];
  int                      errors = 0;
  int                      n_sent = 0;
  int                      n_checked = 0;
  int                      n_sat = 0;
  int                      n_zero = 0;
  int                      idle_cycles = 0;
  int                      burst_left = 0;

  great_circle_travel_time #(.CORDIC_STAGES(ROT_STAGES)) dut (.*);

  always #10 clk_i = ~clk_i;

  // Rotation-mode CORDIC with reduction into plus or minus half pi.
  function automatic void rot_sin_cos(input longint ang, output longint s,
                                      output longint c);
    longint x, y, z, dx, dy;
    bit     flip;
    x = 64'sd652032874;
    y = 0;
    flip = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (ang > HPI_Q30) begin
        ang -= PI_Q30;
        flip = ~flip;
      end else if (ang < -HPI_Q30) begin
        ang += PI_Q30;
        flip = ~flip;
      end
    end
    z = ang;
    for (int i = 0; i < ROT_STAGES && i < TAB_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Vectoring-mode CORDIC; the angle is clamped at zero.
  function automatic longint vec_atan2(input longint y, input longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < ROT_STAGES && i < TAB_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Expected trip time for one point pair at the current radius.
  function automatic trip_t predict_trip(input longint lat1, input longint lon1,
                                         input longint lat2, input longint lon2,
                                         input longint unsigned spd);
    longint          s_lat, s_lon, c1, c2, unused, a, z;
    longint unsigned sa, sb, num, den, t;
    trip_t           r;
    rot_sin_cos((lat2 - lat1) * 2, s_lat, unused);
    rot_sin_cos((lon2 - lon1) * 2, s_lon, unused);
    rot_sin_cos(lat1 * 4, unused, c1);
    rot_sin_cos(lat2 * 4, unused, c2);
    a = ((s_lat * s_lat) >>> 30) + ((((c1 * c2) >>> 30) * ((s_lon * s_lon) >>> 30)) >>> 30);
    if (a < 0) a = 0;
    if (a > ONE_Q30) a = ONE_Q30;
    sa = floor_sqrt(longint'(a) << 30);
    sb = floor_sqrt(longint'(ONE_Q30 - a) << 30);
    z = vec_atan2(sa, sb);
    r.sat = 1'b0;
    r.zero = 1'b0;
    if (spd == 0) begin
      r.secs = TIME_MAX;
      r.zero = 1'b1;
      return r;
    end
    num = longint'(radius_m) * longint'(2 * z);
    den = spd << 6;
    t = num / den;
    if (t > longint'(TIME_MAX)) begin
      t = TIME_MAX;
      r.sat = 1'b1;
    end
    r.secs = t[TIME_W-1:0];
    return r;
  endfunction

  // Record an expectation for every input transfer.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      pending_trips.push_back(predict_trip(longint'(start_lat_i), longint'(start_lon_i),
                                           longint'(end_lat_i), longint'(end_lon_i),
                                           longint'(ground_speed_i)));
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    trip_t e;
    if (rst_ni && done_o) begin
      n_checked++;
      if (pending_trips.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual time %0d", $time,
                 travel_seconds_o);
      end else begin
        e = pending_trips.pop_front();
        if (e.sat) n_sat++;
        if (e.zero) n_zero++;
        if (travel_seconds_o !== e.secs) begin
          errors++;
          $display("%0t: travel_seconds expected %0d actual %0d", $time, e.secs,
                   travel_seconds_o);
        end
        if (time_saturated_o !== e.sat) begin
          errors++;
          $display("%0t: time_saturated expected %0b actual %0b", $time, e.sat,
                   time_saturated_o);
        end
        if (speed_zero_o !== e.zero) begin
          errors++;
          $display("%0t: speed_zero expected %0b actual %0b", $time, e.zero,
                   speed_zero_o);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Send one point pair; bursts of random length, usually separated by random gaps.
  task automatic send_trip(input longint lat1, input longint lon1, input longint lat2,
                           input longint lon2, input longint spd);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    start          <= 1'b1;
    start_lat_i    <= lat1[29:0];
    start_lon_i    <= lon1[30:0];
    end_lat_i      <= lat2[29:0];
    end_lon_i      <= lon2[30:0];
    ground_speed_i <= spd[SPD_W-1:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n_sent++;
  endtask

  // Let the pipeline empty, then load a new radius.
  task automatic write_radius(input logic [RAD_W-1:0] r);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_trips.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radius_m = r;
    @(posedge clk_i);
  endtask

  function automatic longint rand_lat();
    return longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
  endfunction

  // Extremes, identical and antipodal points, zero, tiny and maximum speed.
  task automatic test_directed();
    send_trip(0, 0, 0, 0, 65536);
    send_trip(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, 65536);
    send_trip(0, 0, 0, LON_MAX, 65536);
    send_trip(0, -LON_MAX, 0, LON_MAX, 1 << 20);
    send_trip(LAT_MAX, 0, -LAT_MAX, 0, 1 << 20);
    send_trip(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 1);
    send_trip(LAT_MAX, 0, -LAT_MAX, LON_MAX, 67108863);
    send_trip(1000, 2000, 3000, 4000, 0);
    send_trip(0, 0, 0, 0, 0);
    send_trip(-LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, 2);
    send_trip(10, -10, -10, 10, 67108863);
    send_trip(100000000, 200000000, -150000000, -300000000, 17 * 65536);
    // Full-width codes beyond the stated angle range.
    send_trip(-(1 << 29), -(1 << 30), (1 << 29) - 1, (1 << 30) - 1, 65536);
    send_trip((1 << 29) - 1, (1 << 30) - 1, -(1 << 29), -(1 << 30), 3);
    send_trip(-(1 << 29), 0, 0, -(1 << 30), 40000000);
    send_trip(0, 1, 0, 0, 1);
  endtask

  // Random point pairs; speed spread over zero, small, typical and full range.
  task automatic test_random(input int n);
    longint spd;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       spd = 0;
        1, 2:    spd = $urandom_range(1, 255);
        3, 4, 5: spd = $urandom_range(65536, 300 * 65536);
        default: spd = $urandom_range(0, 67108863);
      endcase
      if ($urandom_range(0, 7) == 0)
        send_trip($signed(30'($urandom)), $signed(31'($urandom)),
                  $signed(30'($urandom)), $signed(31'($urandom)), spd);
      else
        send_trip(rand_lat(), rand_lon(), rand_lat(), rand_lon(), spd);
    end
  endtask

  task automatic test_radius_sweep();
    write_radius(RAD_W'(16777215));
    test_directed();
    test_random(350);
    write_radius(RAD_W'(1));
    test_random(250);
    write_radius(RAD_W'(0));
    test_random(100);
    write_radius(RAD_W'($urandom_range(1, 16777215)));
    test_random(300);
    write_radius(RADIUS_EARTH);
    test_random(250);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(560);
    test_radius_sweep();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_trips.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("Sent %0d point pairs over six radius settings; checked %0d results.", n_sent,
             n_checked);
    $display("Of these %0d saturated and %0d had zero speed.", n_sat, n_zero);
    if (errors == 0 && pending_trips.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
